// ----- sv/plid_pkg.sv -----
// ---------------------------------------------------------------------------
// plid_pkg
// Shared codes and types for the positional list block.
// ---------------------------------------------------------------------------
package plid_pkg;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_DUMP   = 2'd2;

  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_BAD   = 2'd1;
  localparam logic [1:0] STS_EMPTY = 2'd2;

  localparam int MAX_RESULTS = 32;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_DEL  = 2'd2,
    CELL_ROT  = 2'd3
  } cell_op_t;

endpackage

// ----- sv/plid_cell.sv -----
// ---------------------------------------------------------------------------
// plid_cell
// One list entry. Loads the new value, takes a neighbour's value or the
// head value, or holds, depending on the operation and its own place.
// ---------------------------------------------------------------------------
module plid_cell #(
  parameter int IDX = 0,
  parameter int PW  = 6
) (
  input  logic                  clk,
  input  plid_pkg::cell_op_t    op,
  input  logic [PW-1:0]         sel,
  input  logic signed [31:0]    item_value,
  input  logic signed [31:0]    prev_value,
  input  logic signed [31:0]    next_value,
  input  logic signed [31:0]    head_value,
  output logic signed [31:0]    value
);

  localparam logic [PW-1:0] IDX_V = PW'(IDX);

  logic signed [31:0] value_next;

  always_comb begin
    value_next = value;
    unique case (op)
      plid_pkg::CELL_INS: begin
        if (IDX_V == sel) value_next = item_value;
        else if (IDX_V > sel) value_next = prev_value;
      end
      plid_pkg::CELL_DEL: begin
        if (IDX_V >= sel) value_next = next_value;
      end
      plid_pkg::CELL_ROT: begin
        if (IDX_V < sel) value_next = next_value;
        else if (IDX_V == sel) value_next = head_value;
      end
      default: value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

// ----- sv/positional_list_insert_delete.sv -----
// ---------------------------------------------------------------------------
// positional_list_insert_delete
// Ordered list of signed words held in a row of shifting cells.
// Insert, delete and bad commands: result registered, in the cycle after start.
// Dump: busy while the chain rotates one place a cycle, once per entry; one
// result per cycle, registered from the dump state. Empty dump: as for insert.
// Reset (synchronous) clears the length and control; entries are undefined.
// ---------------------------------------------------------------------------
module positional_list_insert_delete #(
  parameter int CAPACITY = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         command,
  input  logic [5:0]         position,
  input  logic signed [31:0] item_value,
  output logic               done,
  output logic signed [31:0] read_value,
  output logic [1:0]         status,
  output logic               last
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > 6) ? CW : 6;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DUMP = 2'b10
  } state_t;

  state_t             state, state_next;
  logic [CW-1:0]      count, count_next;
  logic [CW-1:0]      step, step_next;
  plid_pkg::cell_op_t op;
  logic [PW-1:0]      sel;
  logic [PW-1:0]      pos_x, count_x;
  logic               accept, ins_ok, del_ok;
  logic               done_next, last_next;
  logic [1:0]         status_next;
  logic signed [31:0] read_value_next;
  logic signed [31:0] vals [CAPACITY];
  logic [31:0]        n_m1;

  assign busy    = (state == ST_DUMP);
  assign accept  = start && !busy;
  assign pos_x   = PW'(position);
  assign count_x = PW'(count);
  assign ins_ok  = (count < CW'(CAPACITY)) && (pos_x <= count_x);
  assign del_ok  = (pos_x < count_x);
  assign n_m1    = (32'(count) > 32'(plid_pkg::MAX_RESULTS)) ?
                   32'(plid_pkg::MAX_RESULTS - 1) : 32'(count) - 32'd1;

  always_comb begin
    state_next      = state;
    count_next      = count;
    step_next       = step;
    op              = plid_pkg::CELL_HOLD;
    sel             = pos_x;
    done_next       = 1'b0;
    read_value_next = '0;
    status_next     = plid_pkg::STS_OK;
    last_next       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          done_next = 1'b1;
          last_next = 1'b1;
          case (command)
            plid_pkg::CMD_INSERT: begin
              if (ins_ok) begin
                op         = plid_pkg::CELL_INS;
                count_next = count + CW'(1);
              end else begin
                status_next = plid_pkg::STS_BAD;
              end
            end
            plid_pkg::CMD_DELETE: begin
              if (del_ok) begin
                op         = plid_pkg::CELL_DEL;
                count_next = count - CW'(1);
              end else begin
                status_next = plid_pkg::STS_BAD;
              end
            end
            plid_pkg::CMD_DUMP: begin
              if (count == '0) begin
                status_next = plid_pkg::STS_EMPTY;
              end else begin
                done_next  = 1'b0;
                last_next  = 1'b0;
                step_next  = '0;
                state_next = ST_DUMP;
              end
            end
            default: status_next = plid_pkg::STS_BAD;
          endcase
        end
      end
      ST_DUMP: begin
        op              = plid_pkg::CELL_ROT;
        sel             = count_x - PW'(1);
        done_next       = (32'(step) < 32'(plid_pkg::MAX_RESULTS));
        last_next       = (32'(step) == n_m1);
        read_value_next = vals[0];
        step_next       = step + CW'(1);
        if (step == count - CW'(1)) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      step  <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      step  <= step_next;
      done  <= done_next;
    end
    read_value <= read_value_next;
    status     <= status_next;
    last       <= last_next;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] prev_v, next_v;
    if (i == 0) begin : g_head
      assign prev_v = item_value;
    end else begin : g_mid
      assign prev_v = vals[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign next_v = vals[i];
    end else begin : g_body
      assign next_v = vals[i+1];
    end
    plid_cell #(
      .IDX (i),
      .PW  (PW)
    ) u_cell (
      .clk        (clk),
      .op         (op),
      .sel        (sel),
      .item_value (item_value),
      .prev_value (prev_v),
      .next_value (next_v),
      .head_value (vals[0]),
      .value      (vals[i])
    );
  end

endmodule
